// ===== sv/bbr_pkg.sv =====
// -----------------------------------------------------------------------------
// bbr_pkg
// Shared types, constants and a helper function for the RGB box blur stream.
// -----------------------------------------------------------------------------
package bbr_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_RADIUS = 7;

	// item and position counters: covers width * height plus the flush lag
	localparam int CNT_W  = 26;
	localparam int STEP_W = 5;
	// row sums and column sums for radius up to 15
	localparam int SUM_W  = 13;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RAD_X  = 2'd2;
	localparam logic [1:0] REG_RAD_Y  = 2'd3;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	typedef struct packed {
		logic       op;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_last;
	} res_t;

	typedef struct packed {
		logic [10:0]      w;
		logic [12:0]      h;
		logic [3:0]       rx;
		logic [3:0]       ry;
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] delay;
		logic [CNT_W-1:0] span;
		logic [8:0]       dx;
		logic [8:0]       dy;
	} cfg_t;

	typedef struct packed {
		logic [23:0]      sample;
		logic             has_res;
		logic             last;
		logic [10:0]      ox;
		logic [CNT_W-1:0] oy;
	} job_t;

	// floor(256 / (2r + 1))
	function automatic logic [8:0] rad_recip(input logic [3:0] r);
		logic [8:0] v;
		case (r)
			4'd0:    v = 9'd256;
			4'd1:    v = 9'd85;
			4'd2:    v = 9'd51;
			4'd3:    v = 9'd36;
			4'd4:    v = 9'd28;
			4'd5:    v = 9'd23;
			4'd6:    v = 9'd19;
			4'd7:    v = 9'd17;
			4'd8:    v = 9'd15;
			4'd9:    v = 9'd13;
			4'd10:   v = 9'd12;
			4'd11:   v = 9'd11;
			4'd12:   v = 9'd10;
			4'd13:   v = 9'd9;
			4'd14:   v = 9'd8;
			default: v = 9'd8;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/bbr_fifo.sv =====
// -----------------------------------------------------------------------------
// bbr_fifo
// Two-entry request queue between the front end and the window engine.
// -----------------------------------------------------------------------------
module bbr_fifo import bbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t pop_data
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/bbr_front.sv =====
// -----------------------------------------------------------------------------
// bbr_front
// Accepts pixel and flush requests, keeps the frame count, decides whether a
// result is due and finds its column and row with a serial divider.
// -----------------------------------------------------------------------------
module bbr_front import bbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic pix_valid,
	output logic pix_ready,
	input  pix_t pix_data,
	output logic push,
	output job_t push_data,
	input  logic full
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIVIDE,
		ST_PUSH
	} state_t;

	state_t            state_q;
	pix_t              item_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  num_q;
	logic [10:0]       rem_q;
	logic [STEP_W-1:0] step_q;
	job_t              job_q;

	logic [CNT_W-1:0]  pos;
	logic              has_res;
	logic              last;
	logic [11:0]       trial;
	logic              ge;

	assign pix_ready = (state_q == ST_IDLE);
	assign push      = (state_q == ST_PUSH) && !full;
	assign push_data = job_q;

	assign has_res = (cnt_q >= cfg.delay);
	assign pos     = cnt_q - cfg.delay;
	assign last    = has_res && ((pos + CNT_W'(1)) >= cfg.total);

	// restoring divide of the result position by the row width
	assign trial = {rem_q, num_q[CNT_W-1]};
	assign ge    = (trial >= {1'b0, cfg.w});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			item_q  <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			step_q  <= '0;
			job_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pix_valid) begin
						item_q  <= pix_data;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (item_q.op == OP_PIXEL && cnt_q < cfg.total) begin
						job_q.sample <= {item_q.in_red, item_q.in_green, item_q.in_blue};
					end else begin
						job_q.sample <= '0;
					end
					job_q.has_res <= has_res;
					job_q.last    <= last;
					cnt_q         <= last ? '0 : cnt_q + CNT_W'(1);
					num_q         <= pos;
					rem_q         <= '0;
					step_q        <= STEP_W'(CNT_W - 1);
					state_q       <= has_res ? ST_DIVIDE : ST_PUSH;
				end
				ST_DIVIDE: begin
					rem_q <= ge ? 11'(trial - {1'b0, cfg.w}) : trial[10:0];
					num_q <= {num_q[CNT_W-2:0], ge};
					if (step_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_PUSH: begin
					job_q.oy <= num_q;
					job_q.ox <= rem_q;
					if (!full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// quotient and remainder are final once the divide ends
			if (state_q == ST_DIVIDE && step_q == '0) begin
				job_q.oy <= {num_q[CNT_W-2:0], ge};
				job_q.ox <= ge ? 11'(trial - {1'b0, cfg.w}) : trial[10:0];
			end
		end
	end

endmodule

// ===== sv/bbr_back.sv =====
// -----------------------------------------------------------------------------
// bbr_back
// Window engine: stores each sample in the line store; if a result is due, it
// walks the window one tap per cycle, scales row and column sums, holds result.
// -----------------------------------------------------------------------------
module bbr_back import bbr_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic empty,
	output logic pop,
	input  job_t job,
	output logic res_valid,
	input  logic res_ready,
	output res_t res_data
);

	localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int YW    = CNT_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_ISSUE,
		ST_DRAIN,
		ST_SCALE
	} state_t;

	state_t                state_q;
	job_t                  job_q;
	logic [23:0]           store [DEPTH];
	logic [23:0]           rdata_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         addr_q;
	logic [AW-1:0]         row_addr_q;
	logic [4:0]            col_q;
	logic [4:0]            row_q;
	logic signed [12:0]    x_q;
	logic signed [YW-1:0]  y_q;
	logic                  v_s1;
	logic                  inb_s1;
	logic                  rend_s1;
	logic [SUM_W-1:0]      racc_q [3];
	logic                  v_s2;
	logic [SUM_W-1:0]      rsum_s2 [3];
	logic [SUM_W-1:0]      sacc_q [3];
	logic                  res_valid_q;
	res_t                  res_q;

	logic                  wen;
	logic [AW:0]           start_diff;
	logic [AW-1:0]         start_addr;
	logic [AW:0]           next_row;
	logic [AW-1:0]         next_row_addr;
	logic [AW-1:0]         next_addr;
	logic                  inb;
	logic                  row_end;
	logic signed [12:0]    x_start;
	logic [7:0]            tap [3];
	logic [SUM_W-1:0]      row_total [3];
	logic [SUM_W+8:0]      row_prod [3];
	logic [SUM_W+8:0]      col_prod [3];

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign wen       = (state_q == ST_WRITE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign start_diff    = {1'b0, ptr_q} - {1'b0, cfg.span[AW-1:0]};
	assign start_addr    = start_diff[AW] ? AW'(start_diff + (AW+1)'(DEPTH))
	                                      : start_diff[AW-1:0];
	assign next_row      = {1'b0, row_addr_q} + (AW+1)'(cfg.w);
	assign next_row_addr = (next_row >= (AW+1)'(DEPTH)) ? AW'(next_row - (AW+1)'(DEPTH))
	                                                    : next_row[AW-1:0];
	assign next_addr     = (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + AW'(1);
	assign x_start       = $signed({2'b00, job_q.ox}) - $signed({9'd0, cfg.rx});
	assign row_end       = (col_q == {cfg.rx, 1'b0});
	assign inb = !x_q[12] && (x_q < $signed({2'b00, cfg.w}))
	          && !y_q[YW-1] && (y_q < $signed({(YW-13)'(0), cfg.h}));

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tap[c]       = inb_s1 ? rdata_q[8*c +: 8] : 8'd0;
			row_total[c] = racc_q[c] + SUM_W'(tap[c]);
			row_prod[c]  = rsum_s2[c] * cfg.dx;
			col_prod[c]  = sacc_q[c] * cfg.dy;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			store[ptr_q] <= job_q.sample;
		end
		rdata_q <= store[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			ptr_q       <= '0;
			addr_q      <= '0;
			row_addr_q  <= '0;
			col_q       <= '0;
			row_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			v_s1        <= 1'b0;
			inb_s1      <= 1'b0;
			rend_s1     <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			for (int c = 0; c < 3; c++) begin
				racc_q[c]  <= '0;
				rsum_s2[c] <= '0;
				sacc_q[c]  <= '0;
			end
		end else begin
			if (res_valid_q && res_ready && state_q != ST_SCALE) res_valid_q <= 1'b0;

			// tap accumulate, one row sum handed on at each row end
			v_s1    <= (state_q == ST_ISSUE);
			inb_s1  <= inb;
			rend_s1 <= row_end;
			v_s2    <= v_s1 && rend_s1;
			if (v_s1) begin
				for (int c = 0; c < 3; c++) begin
					if (rend_s1) begin
						rsum_s2[c] <= row_total[c];
						racc_q[c]  <= '0;
					end else begin
						racc_q[c] <= row_total[c];
					end
				end
			end
			if (v_s2) begin
				for (int c = 0; c < 3; c++) begin
					sacc_q[c] <= sacc_q[c] + SUM_W'(row_prod[c] >> 8);
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						job_q   <= job;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (job_q.has_res && job_q.last) begin
						ptr_q <= '0;
					end else begin
						ptr_q <= (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
					end
					addr_q     <= start_addr;
					row_addr_q <= start_addr;
					col_q      <= '0;
					row_q      <= '0;
					x_q        <= x_start;
					y_q        <= $signed({1'b0, job_q.oy}) - $signed({(YW-4)'(0), cfg.ry});
					for (int c = 0; c < 3; c++) begin
						racc_q[c] <= '0;
						sacc_q[c] <= '0;
					end
					state_q <= job_q.has_res ? ST_ISSUE : ST_IDLE;
				end
				ST_ISSUE: begin
					if (row_end) begin
						col_q      <= '0;
						row_q      <= row_q + 5'd1;
						x_q        <= x_start;
						y_q        <= y_q + YW'(1);
						addr_q     <= next_row_addr;
						row_addr_q <= next_row_addr;
						if (row_q == {cfg.ry, 1'b0}) state_q <= ST_DRAIN;
					end else begin
						col_q  <= col_q + 5'd1;
						x_q    <= x_q + 13'sd1;
						addr_q <= next_addr;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q      <= 1'b1;
						res_q.out_red    <= col_prod[2][15:8];
						res_q.out_green  <= col_prod[1][15:8];
						res_q.out_blue   <= col_prod[0][15:8];
						res_q.out_alpha  <= ALPHA_OPAQUE;
						res_q.frame_last <= job_q.last;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/box_blur_rgb_stream.sv =====
// -----------------------------------------------------------------------------
// box_blur_rgb_stream
// Streaming separable RGB box blur with a line store and APB register port.
// -----------------------------------------------------------------------------
//  channel | signals                        | accepted when
//  --------+--------------------------------+---------------------------
//  pixels  | pix_valid, pix_ready, pix_data | pix_valid && pix_ready
//  results | res_valid, res_ready, res_data | res_valid && res_ready
//  config  | APB psel/penable/pwrite/...    | psel && penable && pwrite
//
// The front end takes a request and, when a result is due, runs the 26 divider
// steps before the push, which waits while the queue is full. The engine pops
// and writes a request without a result; with one it also reads (2rx+1)*(2ry+1)
// line store taps, one per cycle, then drains and scales.
// The queue lets the front end take the next request while the engine works.
// Reset clears control state only; the line store is not cleared.
// A stalled result holds in the output register and the engine waits behind it.
module box_blur_rgb_stream import bbr_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  pix_t        pix_data,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [2:0]  rad_x_q;
	logic [2:0]  rad_y_q;
	cfg_t        cfg_q;
	cfg_t        cfg_d;
	logic        wr;

	logic        push;
	job_t        push_data;
	logic        full;
	logic        pop;
	logic        empty;
	job_t        pop_data;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			rad_x_q  <= 3'd1;
			rad_y_q  <= 3'd1;
		end else if (wr) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				REG_RAD_X:  rad_x_q  <= pwdata[2:0];
				REG_RAD_Y:  rad_y_q  <= pwdata[2:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			REG_RAD_X:  prdata = {29'd0, rad_x_q};
			REG_RAD_Y:  prdata = {29'd0, rad_y_q};
			default:    prdata = '0;
		endcase
	end

	// effective settings after clamping, with derived products
	always_comb begin
		cfg_d = '0;
		if (width_q == '0) begin
			cfg_d.w = 11'd1;
		end else if ({2'b00, width_q} > 13'(MAX_WIDTH)) begin
			cfg_d.w = 11'(MAX_WIDTH);
		end else begin
			cfg_d.w = width_q;
		end
		cfg_d.h  = (height_q == '0) ? 13'd1 : height_q;
		cfg_d.rx = ({1'b0, rad_x_q} > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : {1'b0, rad_x_q};
		cfg_d.ry = ({1'b0, rad_y_q} > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : {1'b0, rad_y_q};
		cfg_d.total = CNT_W'(cfg_d.w * cfg_d.h);
		cfg_d.delay = CNT_W'(cfg_d.ry * cfg_d.w) + CNT_W'(cfg_d.rx);
		cfg_d.span  = {cfg_d.delay[CNT_W-2:0], 1'b0};
		cfg_d.dx    = rad_recip(cfg_d.rx);
		cfg_d.dy    = rad_recip(cfg_d.ry);
	end

	always_ff @(posedge clk) begin
		cfg_q <= cfg_d;
	end

	bbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	bbr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	bbr_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.job       (pop_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

// ===== sv/bbr_checker.sv =====
// -----------------------------------------------------------------------------
// bbr_checker
// Port-level checks for the box blur stream, bound to the top level.
// -----------------------------------------------------------------------------
module bbr_checker import bbr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_ready,
	input pix_t        pix_data,
	input logic        res_valid,
	input logic        res_ready,
	input res_t        res_data,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// a held result keeps its data
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.out_alpha == ALPHA_OPAQUE)
		else $error("alpha not opaque");

	// front end is busy the cycle after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("request taken on back-to-back cycles");

	// a read of the x radius register just after a write returns the written value
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == REG_RAD_X
		|=> (psel && !pwrite && paddr[3:2] == REG_RAD_X) |-> prdata[2:0] == $past(pwdata[2:0]))
		else $error("register readback mismatch");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind box_blur_rgb_stream bbr_checker u_bbr_checker (.*);

// ===== tb/box_blur_checker.sv =====
// -----------------------------------------------------------------------------
// box_blur_checker
// Watches the pixel, result and register channels of the box blur. It keeps its
// own copy of the registers and of the line store, predicts each blurred pixel
// and compares it field by field with the result the block hands out.
// -----------------------------------------------------------------------------
module box_blur_checker import bbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	input  logic        pix_ready,
	input  pix_t        pix_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          waiting
);

	localparam int STORE_N = 2 * DEF_MAX_RADIUS * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;

	logic [23:0]  sample_mem [STORE_N];
	logic [10:0]  cfg_w;
	logic [12:0]  cfg_h;
	logic [2:0]   cfg_rx;
	logic [2:0]   cfg_ry;
	int unsigned  frame_pos;
	res_t         blur_q[$];

	function automatic logic [23:0] sample_at(int x, int y, int unsigned w, int unsigned h);
		if (x < 0 || y < 0 || x >= int'(w) || y >= int'(h))
			return 24'd0;
		return sample_mem[(int'(y) * w + x) % STORE_N];
	endfunction

	// one pixel request in; returns 1 with the blurred pixel when one is due
	function automatic bit blur_step(input pix_t d, output res_t r);
		int unsigned w, h, rx, ry, total, lag, i, p, dxm, dym;
		int unsigned sr, sg, sb, rr, rg, rb;
		int ox, oy, kx, ky;
		logic [23:0] s;
		w = (cfg_w == 0) ? 1 : ((cfg_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_w);
		h = (cfg_h == 0) ? 1 : cfg_h;
		rx = (cfg_rx > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : cfg_rx;
		ry = (cfg_ry > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : cfg_ry;
		total = w * h;
		lag = ry * w + rx;
		i = frame_pos;
		s = (d.op == OP_PIXEL && i < total) ? {d.in_red, d.in_green, d.in_blue} : 24'd0;
		sample_mem[i % STORE_N] = s;
		frame_pos = i + 1;
		r = '0;
		if (i < lag)
			return 0;
		p = i - lag;
		ox = p % w;
		oy = p / w;
		dxm = 256 / (2 * rx + 1);
		dym = 256 / (2 * ry + 1);
		sr = 0; sg = 0; sb = 0;
		for (ky = -int'(ry); ky <= int'(ry); ky++) begin
			rr = 0; rg = 0; rb = 0;
			for (kx = -int'(rx); kx <= int'(rx); kx++) begin
				s = sample_at(ox + kx, oy + ky, w, h);
				rr += s[23:16];
				rg += s[15:8];
				rb += s[7:0];
			end
			sr += (rr * dxm) >> 8;
			sg += (rg * dxm) >> 8;
			sb += (rb * dxm) >> 8;
		end
		r.out_red = ((sr * dym) >> 8) & 8'hff;
		r.out_green = ((sg * dym) >> 8) & 8'hff;
		r.out_blue = ((sb * dym) >> 8) & 8'hff;
		r.out_alpha = ALPHA_OPAQUE;
		r.frame_last = (p + 1 >= total);
		if (r.frame_last)
			frame_pos = 0;
		return 1;
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t r;
		res_t e;
		if (!arst_n) begin
			cfg_w <= 11'd1024;
			cfg_h <= 13'd1024;
			cfg_rx <= 3'd1;
			cfg_ry <= 3'd1;
			frame_pos = 0;
			fail_count = 0;
			blur_q.delete();
			waiting = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WIDTH:  cfg_w <= pwdata[10:0];
					REG_HEIGHT: cfg_h <= pwdata[12:0];
					REG_RAD_X:  cfg_rx <= pwdata[2:0];
					REG_RAD_Y:  cfg_ry <= pwdata[2:0];
					default:    ;
				endcase
			end
			if (pix_valid && pix_ready && blur_step(pix_data, r))
				blur_q.push_back(r);
			if (res_valid && res_ready) begin
				if (blur_q.size() == 0) begin
					$error("result with nothing expected");
					fail_count++;
				end else begin
					e = blur_q.pop_front();
					check_field("out_red", e.out_red, res_data.out_red);
					check_field("out_green", e.out_green, res_data.out_green);
					check_field("out_blue", e.out_blue, res_data.out_blue);
					check_field("out_alpha", e.out_alpha, res_data.out_alpha);
					check_field("frame_last", e.frame_last, res_data.frame_last);
				end
			end
			waiting = blur_q.size();
		end
	end

endmodule

// ===== tb/tb_box_blur_rgb_stream.sv =====
// -----------------------------------------------------------------------------
// tb_box_blur_rgb_stream
// Runs whole frames through the box blur under many register settings, with
// bursty pixel requests and a stalling result side; a checker beside the block
// predicts and compares every result.
// -----------------------------------------------------------------------------
module tb_box_blur_rgb_stream;
	import bbr_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 400;

	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_ready;
	pix_t        pix_data;
	logic        res_valid;
	logic        res_ready;
	res_t        res_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          waiting;
	int          idle_cycles = 0;
	int          burst_left;
	int          sent;
	bit          hold_req;

	box_blur_rgb_stream DUT (.*);

	box_blur_checker chk (
		.clk, .arst_n, .pix_valid, .pix_ready, .pix_data, .res_valid, .res_ready,
		.res_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .waiting
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// result side: stall pattern changes at random; one long hold on request
	initial begin
		int mode;
		int hold;
		bit hold_seen;
		res_ready = 1'b0;
		mode = 0;
		hold = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen) begin
				hold = 2000;
				hold_seen = 1;
			end
			if ($urandom_range(63, 0) == 0)
				mode = $urandom_range(2, 0);
			if (hold > 0) begin
				hold--;
				res_ready <= 1'b0;
			end else begin
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= $urandom_range(1, 0);
					default: res_ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("box_blur_rgb_stream test failed");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_pix(input pix_t d);
		if (burst_left == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = ($urandom_range(3, 0) == 0) ? 200 : $urandom_range(12, 1);
		end
		burst_left--;
		pix_valid <= 1'b1;
		pix_data <= d;
		do @(posedge clk); while (!pix_ready);
		sent++;
	endtask

	function automatic logic [7:0] chan_val(int mode);
		case (mode)
			1: return 8'h00;
			2: return 8'hff;
			default: return ($urandom_range(7, 0) == 0) ? ($urandom_range(1, 0) ? 8'hff : 8'h00)
				: $urandom_range(255, 0);
		endcase
	endfunction

	// fill mode: 0 random, 1 all zero, 2 all full scale
	task automatic run_frame(input int w, input int h, input int rx, input int ry,
			input int fill);
		int we, he, lag, n;
		pix_t d;
		pix_valid <= 1'b0;
		wait (waiting == 0);
		repeat (SETTLE) @(posedge clk);
		reg_write(REG_WIDTH, 32'(w));
		reg_write(REG_HEIGHT, 32'(h));
		reg_write(REG_RAD_X, 32'(rx));
		reg_write(REG_RAD_Y, 32'(ry));
		we = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
		he = (h == 0) ? 1 : h;
		lag = ry * we + rx;
		for (n = 0; n < we * he + lag; n++) begin
			d.in_red = chan_val(fill);
			d.in_green = chan_val(fill);
			d.in_blue = chan_val(fill);
			// flush slots inside the frame, flush or pixel requests in the drain phase
			if (n < we * he)
				d.op = (fill == 0 && $urandom_range(15, 0) == 0) ? OP_FLUSH : OP_PIXEL;
			else
				d.op = $urandom_range(1, 0) ? OP_FLUSH : OP_PIXEL;
			send_pix(d);
		end
	endtask

	initial begin
		int f;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 0;
		burst_left = 0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_frame(1, 1, 0, 0, 0);
		run_frame(0, 0, 1, 1, 0);
		run_frame(5, 4, 7, 7, 2);
		run_frame(3, 2, 7, 7, 1);
		run_frame(4, 3, 0, 7, 2);
		run_frame(6, 2, 7, 0, 0);

		f = 0;
		while (sent < 1000) begin
			if (f == 3)
				hold_req = 1;
			if (f == 3)
				run_frame(24, 6, $urandom_range(7, 0), $urandom_range(2, 0), 0);
			else
				run_frame($urandom_range(24, 1), $urandom_range(6, 1),
					$urandom_range(7, 0), $urandom_range(7, 0), 0);
			f++;
		end

		pix_valid <= 1'b0;
		wait (waiting == 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("box_blur_rgb_stream test passed");
		else
			$display("box_blur_rgb_stream test failed");
		$finish;
	end

endmodule
